/* rtl/rtw_pkg.sv */
package rtw_pkg;

  // defaults for the top level parameters
  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxWindowDef = 15;

  // fixed frame limits and field widths
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned GeomW     = 13;
  localparam int unsigned RowW      = 12;
  localparam int unsigned RadW      = 3;
  localparam int unsigned PixW      = 8;
  localparam int unsigned RankW     = 8;
  localparam int unsigned PaddrW    = 4;
  localparam int unsigned PdataW    = 32;

  localparam logic CMD_PIXEL = 1'b0;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2
  } rtw_reg_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CHK  = 5'b00010,
    S_SCAN = 5'b00100,
    S_TAIL = 5'b01000,
    S_OUT  = 5'b10000
  } rtw_state_e;

  // frame geometry after clamping
  typedef struct packed {
    logic [GeomW-1:0] width;
    logic [GeomW-1:0] height;
    logic [RadW-1:0]  radius;
  } rtw_geom_t;

endpackage

/* rtl/rtw_line_store.sv */
module rtw_line_store #(
  parameter int unsigned DEPTH = rtw_pkg::MaxWidthDef * rtw_pkg::MaxWindowDef,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [rtw_pkg::PixW-1:0]  wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [rtw_pkg::PixW-1:0]  rdata_o
);
  import rtw_pkg::*;

  logic [PixW-1:0] mem [DEPTH];
  logic [PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rtw_cfg_regs.sv */
module rtw_cfg_regs #(
  parameter int unsigned MAX_WIDTH  = rtw_pkg::MaxWidthDef,
  parameter int unsigned MAX_WINDOW = rtw_pkg::MaxWindowDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rtw_pkg::PaddrW-1:0]  paddr,
  input  logic [rtw_pkg::PdataW-1:0]  pwdata,
  output logic [rtw_pkg::PdataW-1:0]  prdata,
  output logic                        pready,
  output rtw_pkg::rtw_geom_t          geom_o,
  output logic                        restart_o
);
  import rtw_pkg::*;

  localparam logic [RadW-1:0] RadCap = RadW'((MAX_WINDOW - 1) / 2);

  logic [10:0]      width_q;
  logic [12:0]      height_q;
  logic [RadW-1:0]  radius_q;
  logic             wr_en;
  rtw_reg_e         idx;
  logic [GeomW-1:0] w_eff, h_eff;
  logic [RadW-1:0]  r_eff;

  assign idx    = rtw_reg_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd640;
      height_q <= 13'd480;
      radius_q <= 3'd3;
    end else if (wr_en) begin
      unique case (idx)
        REG_WIDTH:  width_q  <= pwdata[10:0];
        REG_HEIGHT: height_q <= pwdata[12:0];
        REG_RADIUS: radius_q <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  assign restart_o = wr_en && (idx == REG_WIDTH || idx == REG_HEIGHT || idx == REG_RADIUS);

  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = PdataW'(width_q);
      REG_HEIGHT: prdata = PdataW'(height_q);
      REG_RADIUS: prdata = PdataW'(radius_q);
      default:    prdata = '0;
    endcase
  end

  // clamp geometry and saturate the radius
  always_comb begin
    if (width_q == '0) begin
      w_eff = GeomW'(1);
    end else if (GeomW'(width_q) > GeomW'(MAX_WIDTH)) begin
      w_eff = GeomW'(MAX_WIDTH);
    end else begin
      w_eff = GeomW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = GeomW'(1);
    end else if (GeomW'(height_q) > GeomW'(MaxHeight)) begin
      h_eff = GeomW'(MaxHeight);
    end else begin
      h_eff = GeomW'(height_q);
    end
    r_eff = radius_q;
    if (r_eff > RadCap) begin
      r_eff = RadCap;
    end
    if (GeomW'(r_eff) > w_eff - GeomW'(1)) begin
      r_eff = RadW'(w_eff - GeomW'(1));
    end
    if (GeomW'(r_eff) > h_eff - GeomW'(1)) begin
      r_eff = RadW'(h_eff - GeomW'(1));
    end
  end

  assign geom_o = '{width: w_eff, height: h_eff, radius: r_eff};

endmodule

/* rtl/rank_transform_window.sv */
// rank transform over a square (2r+1)x(2r+1) window of an 8-bit grey frame
// arriving in raster order, edges reflected without repeating the edge pixel.
// pixels go into a single line store ring of MAX_WINDOW*MAX_WIDTH bytes; every
// input transfer (pixel or drain) yields at most one rank, the next one in
// raster order whose window is fully received, and frame_last_o marks the
// frame's final rank. one item at a time: an item that yields a rank reads its
// window through the single read port of the line store, one window pixel per
// cycle. a finished rank sits in an output register, so the next item is taken
// while it waits. a write to the width, height or radius register abandons the
// frame; the store needs no clearing.
module rank_transform_window #(
  parameter int unsigned MAX_WIDTH  = rtw_pkg::MaxWidthDef,
  parameter int unsigned MAX_WINDOW = rtw_pkg::MaxWindowDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // apb configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rtw_pkg::PaddrW-1:0]  paddr,
  input  logic [rtw_pkg::PdataW-1:0]  pwdata,
  output logic [rtw_pkg::PdataW-1:0]  prdata,
  output logic                        pready,
  // input item
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic [rtw_pkg::PixW-1:0]    pixel_value_i,
  // result item
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rtw_pkg::RankW-1:0]   rank_value_o,
  output logic                        frame_last_o
);
  import rtw_pkg::*;

  localparam int unsigned Depth = MAX_WINDOW * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned SW    = 20; // signed address arithmetic
  localparam logic signed [SW-1:0] DepthS = SW'(Depth);
  localparam logic [AW-1:0] AddrLast = AW'(Depth - 1);

  rtw_geom_t        geom;
  logic             cfg_restart;
  logic [GeomW-1:0] w, h, wl, hl;
  logic [RadW-1:0]  r;

  rtw_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .geom_o    (geom),
    .restart_o (cfg_restart)
  );

  assign w  = geom.width;
  assign h  = geom.height;
  assign r  = geom.radius;
  assign wl = w - GeomW'(1);
  assign hl = h - GeomW'(1);

  // control and position registers
  rtw_state_e       state_q, state_d;
  logic [XW-1:0]    in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RowW-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic             in_done_q, in_done_d;
  logic [AW-1:0]    wr_addr_q, wr_addr_d, out_base_q, out_base_d;
  logic signed [3:0] dy_q, dy_d, dx_q, dx_d;
  logic             first_q, first_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;
  // payload registers
  logic [PixW-1:0]  centre_q, centre_d;
  logic [RankW-1:0] rank_q, rank_d;
  logic [RankW-1:0] rank_out_q, rank_out_d;
  logic             last_out_q, last_out_d;

  // line store ports
  logic             st_we, st_re;
  logic [AW-1:0]    st_raddr;
  logic [PixW-1:0]  st_rdata;

  logic             in_xfer;
  logic signed [3:0] rs;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign st_we      = in_xfer && (command_i == CMD_PIXEL) && !in_done_q;
  assign rs         = 4'(r);

  rtw_line_store #(
    .DEPTH (Depth),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (wr_addr_q),
    .wdata_i (pixel_value_i),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // window address: reflect-101 per axis, then base + dy*w + dx around the ring
  logic signed [13:0]   prow, pcol, hl_s, wl_s;
  logic signed [4:0]    dyr, dxr;
  logic signed [SW-1:0] w_s, base_s, offs, sum, wrapped;
  logic [AW-1:0]        win_addr;

  always_comb begin
    hl_s = 14'(hl);
    wl_s = 14'(wl);
    prow = 14'(out_row_q) + 14'(dy_q);
    if (prow < 0) begin
      prow = -prow;
    end
    if (prow > hl_s) begin
      prow = (hl_s <<< 1) - prow;
    end
    pcol = 14'(out_col_q) + 14'(dx_q);
    if (pcol < 0) begin
      pcol = -pcol;
    end
    if (pcol > wl_s) begin
      pcol = (wl_s <<< 1) - pcol;
    end
    dyr    = 5'(prow - 14'(out_row_q));
    dxr    = 5'(pcol - 14'(out_col_q));
    w_s    = SW'(w);
    base_s = SW'(out_base_q);
    offs   = SW'(dyr) * w_s + SW'(dxr);
    sum    = base_s + offs;
    if (sum < 0) begin
      wrapped = sum + DepthS;
    end else if (sum >= DepthS) begin
      wrapped = sum - DepthS;
    end else begin
      wrapped = sum;
    end
    win_addr = AW'(wrapped);
  end

  // readiness of the next output position
  logic [GeomW-1:0] need_row, need_col;
  logic             out_range, win_ready, at_last;

  always_comb begin
    need_row = GeomW'(out_row_q) + GeomW'(r);
    if (need_row > hl) begin
      need_row = hl;
    end
    need_col = GeomW'(out_col_q) + GeomW'(r);
    if (need_col > wl) begin
      need_col = wl;
    end
    out_range = (GeomW'(out_row_q) >= h) || (GeomW'(out_col_q) >= w);
    win_ready = in_done_q || (need_row < GeomW'(in_row_q))
             || ((need_row == GeomW'(in_row_q)) && (need_col < GeomW'(in_col_q)));
    at_last   = (GeomW'(out_row_q) == hl) && (GeomW'(out_col_q) == wl);
  end

  always_comb begin
    state_d     = state_q;
    in_col_d    = in_col_q;
    in_row_d    = in_row_q;
    in_done_d   = in_done_q;
    wr_addr_d   = wr_addr_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_base_d  = out_base_q;
    dy_d        = dy_q;
    dx_d        = dx_q;
    first_d     = first_q;
    last_d      = last_q;
    centre_d    = centre_q;
    rank_d      = rank_q;
    rank_out_d  = rank_out_q;
    last_out_d  = last_out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    st_re       = 1'b0;
    st_raddr    = win_addr;

    // store the pixel and move the write position
    if (st_we) begin
      wr_addr_d = (wr_addr_q == AddrLast) ? '0 : wr_addr_q + AW'(1);
      if (GeomW'(in_col_q) == wl) begin
        in_col_d = '0;
        if (GeomW'(in_row_q) == hl) begin
          in_row_d  = '0;
          in_done_d = 1'b1;
        end else begin
          in_row_d = in_row_q + RowW'(1);
        end
      end else begin
        in_col_d = in_col_q + XW'(1);
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (out_range) begin
          state_d    = S_IDLE;
          in_col_d   = '0;
          in_row_d   = '0;
          in_done_d  = 1'b0;
          wr_addr_d  = '0;
          out_col_d  = '0;
          out_row_d  = '0;
          out_base_d = '0;
        end else if (win_ready) begin
          // fetch the centre pixel first
          st_re    = 1'b1;
          st_raddr = out_base_q;
          dy_d     = -rs;
          dx_d     = -rs;
          first_d  = 1'b1;
          rank_d   = '0;
          last_d   = at_last;
          state_d  = S_SCAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        st_re = 1'b1;
        if (first_q) begin
          centre_d = st_rdata;
          first_d  = 1'b0;
        end else if (st_rdata < centre_q) begin
          rank_d = rank_q + RankW'(1);
        end
        if (dx_q == rs) begin
          dx_d = -rs;
          dy_d = dy_q + 4'sd1;
          if (dy_q == rs) begin
            state_d = S_TAIL;
          end
        end else begin
          dx_d = dx_q + 4'sd1;
        end
      end
      S_TAIL: begin
        if (st_rdata < centre_q) begin
          rank_d = rank_q + RankW'(1);
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        // wait for a free output register
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          rank_out_d  = rank_q;
          last_out_d  = last_q;
          state_d     = S_IDLE;
          if (last_q) begin
            in_col_d   = '0;
            in_row_d   = '0;
            in_done_d  = 1'b0;
            wr_addr_d  = '0;
            out_col_d  = '0;
            out_row_d  = '0;
            out_base_d = '0;
          end else begin
            out_base_d = (out_base_q == AddrLast) ? '0 : out_base_q + AW'(1);
            if (GeomW'(out_col_q) == wl) begin
              out_col_d = '0;
              out_row_d = out_row_q + RowW'(1);
            end else begin
              out_col_d = out_col_q + XW'(1);
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // a write to the width, height or radius register abandons the frame
    if (cfg_restart) begin
      state_d    = S_IDLE;
      in_col_d   = '0;
      in_row_d   = '0;
      in_done_d  = 1'b0;
      wr_addr_d  = '0;
      out_col_d  = '0;
      out_row_d  = '0;
      out_base_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_done_q   <= 1'b0;
      wr_addr_q   <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_base_q  <= '0;
      dy_q        <= '0;
      dx_q        <= '0;
      first_q     <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      in_done_q   <= in_done_d;
      wr_addr_q   <= wr_addr_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      out_base_q  <= out_base_d;
      dy_q        <= dy_d;
      dx_q        <= dx_d;
      first_q     <= first_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    centre_q   <= centre_d;
    rank_q     <= rank_d;
    rank_out_q <= rank_out_d;
    last_out_q <= last_out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign rank_value_o = rank_out_q;
  assign frame_last_o = last_out_q;

endmodule

/* rtl/rtw_checker.sv */
module rtw_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        pready,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [rtw_pkg::RankW-1:0]   rank_value_o,
  input logic                        frame_last_o
);
  import rtw_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rank_value_o)
      && $stable(frame_last_o))
    else $error("stalled result changed");

  // a window of at most 15x15 has at most 224 pixels below the centre
  a_rank_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rank_value_o <= 8'd224)
    else $error("rank out of range");

  // every item is checked before the next one is taken
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("back-to-back input transfer");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind rank_transform_window rtw_checker u_rtw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pready       (pready),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .rank_value_o (rank_value_o),
  .frame_last_o (frame_last_o)
);

/* tb/sv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtw_pkg::*;

  // drain command is the complement of the pixel command
  localparam logic CMD_DRAIN = ~CMD_PIXEL;
  // an unmapped register slot, used to show that such writes change nothing
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int unsigned StoreDepth = MaxWindowDef * MaxWidthDef;
  localparam int unsigned ItemTarget = 1700;
  localparam int unsigned SettleCycles = 300;  // longer than one rank (r = 7)
  localparam longint unsigned CycleLimit = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [PdataW-1:0] pwdata = '0;
  logic [PdataW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic command_i = CMD_DRAIN;
  logic [PixW-1:0] pixel_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [RankW-1:0] rank_value_o;
  logic frame_last_o;

  always #2 clk_i = ~clk_i;

  rank_transform_window dut (.*);

  // ---------------------------------------------------------------------------
  // rank predictor: its own copy of the geometry registers, line store and
  // raster counters, stepped once per accepted input transfer
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [RankW-1:0] rank;
    logic             last;
  } rank_t;

  logic [10:0] cfg_width;
  logic [12:0] cfg_height;
  logic [2:0]  cfg_radius;
  logic [PixW-1:0] line_mem [StoreDepth];
  int unsigned wr_row, wr_col, rd_row, rd_col;
  bit frame_in;        // whole frame received
  bit frame_closed;    // last rank of a frame was predicted

  rank_t pending_ranks[$];

  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned ranks_seen = 0;
  int unsigned frames_seen = 0;
  int unsigned geometries = 0;
  longint unsigned cycles = 0;

  function automatic int unsigned geom_w();
    if (cfg_width == 0) return 1;
    if (cfg_width > MaxWidthDef) return MaxWidthDef;
    return cfg_width;
  endfunction

  function automatic int unsigned geom_h();
    if (cfg_height == 0) return 1;
    if (cfg_height > MaxHeight) return MaxHeight;
    return cfg_height;
  endfunction

  function automatic int unsigned geom_r(int unsigned w, int unsigned h);
    int unsigned r;
    r = cfg_radius;
    if (r > (MaxWindowDef - 1) / 2) r = (MaxWindowDef - 1) / 2;
    if (r > w - 1) r = w - 1;
    if (r > h - 1) r = h - 1;
    return r;
  endfunction

  // reflect-101: mirror about the edge pixel without repeating it
  function automatic int unsigned mirror(int p, int unsigned n);
    int top;
    top = int'(n) - 1;
    if (p < 0) p = -p;
    if (p > top) p = 2 * top - p;
    if (p < 0) p = 0;
    return p;
  endfunction

  function automatic logic [PixW-1:0] mem_at(int unsigned row, int unsigned col,
                                             int unsigned w);
    return line_mem[(row * w + col) % StoreDepth];
  endfunction

  function automatic void restart_counters();
    wr_row = 0; wr_col = 0; rd_row = 0; rd_col = 0;
    frame_in = 1'b0;
  endfunction

  // returns 1 when the transfer yields a rank, placed in res
  function automatic bit rank_step(logic cmd, logic [PixW-1:0] pix, output rank_t res);
    int unsigned w, h, r, need_r, need_c, centre, cnt, ry, rx;
    w = geom_w();
    h = geom_h();
    r = geom_r(w, h);
    res = '0;
    if (cmd == CMD_PIXEL && !frame_in) begin
      line_mem[(wr_row * w + wr_col) % StoreDepth] = pix;
      wr_col++;
      if (wr_col >= w) begin
        wr_col = 0;
        wr_row++;
        if (wr_row >= h) begin
          wr_row = 0;
          frame_in = 1'b1;
        end
      end
    end
    if (rd_row >= h || rd_col >= w) begin
      restart_counters();
      return 0;
    end
    need_r = (rd_row + r > h - 1) ? h - 1 : rd_row + r;
    need_c = (rd_col + r > w - 1) ? w - 1 : rd_col + r;
    if (!frame_in && !(need_r * w + need_c < wr_row * w + wr_col)) return 0;
    centre = mem_at(rd_row, rd_col, w);
    cnt = 0;
    for (int dy = -int'(r); dy <= int'(r); dy++) begin
      ry = mirror(int'(rd_row) + dy, h);
      for (int dx = -int'(r); dx <= int'(r); dx++) begin
        rx = mirror(int'(rd_col) + dx, w);
        if (mem_at(ry, rx, w) < centre) cnt++;
      end
    end
    res.rank = cnt[RankW-1:0];
    res.last = (rd_row == h - 1) && (rd_col == w - 1);
    if (res.last) begin
      restart_counters();
      frame_closed = 1'b1;
    end else begin
      rd_col++;
      if (rd_col >= w) begin
        rd_col = 0;
        rd_row++;
      end
    end
    return 1;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // result checker, sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rank_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      ranks_seen++;
      if (pending_ranks.size() == 0) begin
        report_mismatch("unexpected rank transfer", rank_value_o, 0);
      end else begin
        want = pending_ranks.pop_front();
        if (rank_value_o !== want.rank) report_mismatch("rank_value", rank_value_o, want.rank);
        if (frame_last_o !== want.last) report_mismatch("frame_last", frame_last_o, want.last);
        if (want.last) frames_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d ranks outstanding", cycles,
               pending_ranks.size());
      $display("rank_transform_window verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver side: random backpressure, with stretches of none at all
  // ---------------------------------------------------------------------------
  bit sink_free = 1'b0;

  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  initial begin
    int unsigned stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        if (!sink_free && $urandom_range(3) == 0) stall = gap_len();
      end
      if ($urandom_range(499) == 0) sink_free = ~sink_free;
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  bit source_free = 1'b0;

  // one input transfer; called and returns at a falling edge
  task automatic send_item(logic cmd, logic [PixW-1:0] pix, bit typed = 0,
                           rank_t typed_res = '0, bit typed_has = 0);
    rank_t res;
    bit has;
    int unsigned gap;
    gap = source_free ? 0 : gap_len();
    repeat (gap) @(negedge clk_i);
    in_valid_i = 1'b1;
    command_i = cmd;
    pixel_value_i = pix;
    do @(posedge clk_i); while (!in_ready_o);
    has = rank_step(cmd, pix, res);
    // rows with a typed answer take it in place of the prediction
    if (typed) begin
      has = typed_has;
      res = typed_res;
    end
    if (has) pending_ranks.push_back(res);
    items_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    command_i = $urandom_range(1);
    pixel_value_i = $urandom_range(255);
  endtask

  // wait out every outstanding rank plus one full rank computation
  task automatic drain_out();
    while (pending_ranks.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [PdataW-1:0] value);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_WIDTH:  cfg_width = value[10:0];
      REG_HEIGHT: cfg_height = value[12:0];
      REG_RADIUS: cfg_radius = value[2:0];
      default:    ;
    endcase
    if (idx != REG_SPARE) restart_counters();
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned r);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_RADIUS, r);
    geometries++;
  endtask

  // pixel value with a bias toward ties and near-ties
  function automatic logic [PixW-1:0] pick_pixel(int unsigned style);
    case (style)
      0: return $urandom_range(3);
      1: return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return $urandom_range(255);
    endcase
  endfunction

  // one frame with random content; drains are mixed in, and once the frame
  // is complete stray pixels are sent too, which the block must drop
  task automatic run_frame(int unsigned cut_at);
    int unsigned total, sent, style;
    bit paused;
    total = geom_w() * geom_h();
    sent = 0;
    style = $urandom_range(3);
    paused = 1'b0;
    frame_closed = 1'b0;
    while (!frame_closed) begin
      if (cut_at != 0 && sent >= cut_at) break;
      if (sent < total && $urandom_range(9) < 8) begin
        send_item(CMD_PIXEL, pick_pixel(style));
        sent++;
      end else if (sent >= total && $urandom_range(3) == 0) begin
        send_item(CMD_PIXEL, pick_pixel(style));
      end else begin
        send_item(CMD_DRAIN, $urandom_range(255));
      end
      // hold off now and then until every outstanding rank is back
      if (!paused && sent == total / 2 && $urandom_range(3) == 0) begin
        paused = 1'b1;
        while (pending_ranks.size() != 0) @(negedge clk_i);
      end
    end
  endtask

  typedef struct {
    logic  cmd;
    logic [PixW-1:0] pix;
    bit    typed;
    bit    has;
    rank_t res;
  } stim_row_t;

  // 1x1 frames (width and height of zero act as one): every pixel is its own
  // frame, rank zero and marked last; a drain after it yields nothing
  stim_row_t directed[] = '{
    '{CMD_PIXEL, 8'hFF, 1, 1, '{8'd0, 1'b1}},
    '{CMD_DRAIN, 8'hFF, 1, 0, '{8'd0, 1'b0}},
    '{CMD_PIXEL, 8'h00, 1, 1, '{8'd0, 1'b1}},
    '{CMD_DRAIN, 8'h00, 1, 0, '{8'd0, 1'b0}},
    '{CMD_PIXEL, 8'hA5, 1, 1, '{8'd0, 1'b1}},
    '{CMD_PIXEL, 8'h5A, 1, 1, '{8'd0, 1'b1}},
    '{CMD_DRAIN, 8'h5A, 0, 0, '{8'd0, 1'b0}},
    '{CMD_PIXEL, 8'h01, 0, 0, '{8'd0, 1'b0}}
  };

  initial begin
    cfg_width = 11'd640;
    cfg_height = 13'd480;
    cfg_radius = 3'd3;
    restart_counters();
    frame_closed = 1'b0;
    foreach (line_mem[i]) line_mem[i] = '0;

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: degenerate geometry, radius clamps to zero
    set_geometry(0, 0, 7);
    foreach (directed[i])
      send_item(directed[i].cmd, directed[i].pix, directed[i].typed,
                directed[i].res, directed[i].has);
    drain_out();

    // spare slot must leave the geometry alone
    reg_write(REG_SPARE, 32'hFFFF_FFFF);

    // smallest legal frame at the largest radius, then a wide register value
    // that saturates at the line length, abandoned part way
    set_geometry(8, 8, 7);
    run_frame(0);
    drain_out();
    set_geometry(2047, 0, 7);
    run_frame(40);
    drain_out();
    // tallest height saturates, single column, abandoned part way
    set_geometry(1, 8191, 5);
    run_frame(30);
    drain_out();
    // widest legal row over a short frame, abandoned before any window fills
    set_geometry(1024, 8, 7);
    run_frame(60);
    drain_out();

    // random geometries and frames, mostly small so ranks come often
    while (items_sent < ItemTarget) begin
      source_free = ($urandom_range(4) == 0);
      set_geometry($urandom_range(16, 8), $urandom_range(12, 8), $urandom_range(7));
      run_frame(($urandom_range(9) == 0) ? $urandom_range(60, 5) : 0);
      drain_out();
    end

    $display("%0d input transfers over %0d geometries, %0d ranks checked, %0d frames closed",
             items_sent, geometries, ranks_seen, frames_seen);
    if (errors == 0) begin
      $display("rank_transform_window verification clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("rank_transform_window verification failed");
    end
    $finish;
  end

endmodule
